### hdl/keyed_value_cache_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyed value cache table.
// ----------------------------------------------------------------------------
`ifndef KEYED_VALUE_CACHE_TABLE_MACROS_SVH
`define KEYED_VALUE_CACHE_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KVCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kvct assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KVCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kvct assertion failed");

`endif

### hdl/kvct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvct_pkg
// Types and codes shared by the keyed value cache table and its cells.
// ----------------------------------------------------------------------------
package kvct_pkg;

	// Command codes.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] clause_key;
		logic signed [31:0] local_id;
		logic signed [31:0] global_id;
		logic [63:0]        value_bits;
	} kvct_req_t;

	typedef struct packed {
		logic        found;
		logic [63:0] found_value;
		logic [1:0]  status;
	} kvct_rsp_t;

	// Token that walks down the row of cells, one cell per cycle.
	typedef struct packed {
		logic        vld;
		logic [1:0]  cmd;
		logic [31:0] clause_key;
		logic [31:0] local_id;
		logic [31:0] global_id;
		logic [63:0] value_bits;
		logic        hit;
		logic [63:0] hit_value;
		logic        dup;
	} kvct_tok_t;

endpackage

### hdl/kvct_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvct_cell
// One table slot: holds an entry, checks the passing token against it, stores
// a new entry when the token reaches the first free slot, and hands the token
// to the next cell.
// ----------------------------------------------------------------------------
module kvct_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kvct_pkg::kvct_tok_t tok_in,
	input  logic [CW-1:0]     count,
	output kvct_pkg::kvct_tok_t tok_out
);
	import kvct_pkg::*;

	localparam logic [CW-1:0] SLOT = CW'(INDEX);

	logic [31:0] clause_key_q;
	logic [31:0] local_id_q;
	logic [31:0] global_id_q;
	logic [63:0] value_q;
	kvct_tok_t   tok_q;
	kvct_tok_t   tok_d;
	logic        live;
	logic        match_pair;
	logic        match_all;
	logic        wr_en;

	// Only slots below the fill count hold an entry.
	assign live       = (SLOT < count);
	assign match_pair = (clause_key_q == tok_in.clause_key) &&
	                    (global_id_q == tok_in.global_id);
	assign match_all  = match_pair && (local_id_q == tok_in.local_id);

	// Every live slot lies ahead of the first free one, so the duplicate
	// flag is final when the token reaches it.
	assign wr_en = tok_in.vld && (tok_in.cmd == CMD_INSERT) && !tok_in.dup &&
	               (SLOT == count);

	always_comb begin
		tok_d = tok_in;
		if (tok_in.vld && live) begin
			if ((tok_in.cmd == CMD_LOOKUP) && !tok_in.hit && match_pair) begin
				tok_d.hit       = 1'b1;
				tok_d.hit_value = value_q;
			end
			if ((tok_in.cmd == CMD_INSERT) && match_all) begin
				tok_d.dup = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			clause_key_q <= tok_in.clause_key;
			local_id_q   <= tok_in.local_id;
			global_id_q  <= tok_in.global_id;
			value_q      <= tok_in.value_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

### hdl/keyed_value_cache_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_value_cache_table
// Associative table of keyed 64-bit values built as a row of slot cells.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/req_stall kvct_req_t (command, keys, value)
//   rsp      out        rsp_valid/rsp_stall kvct_rsp_t (found, value, status)
//
// One transaction at a time: the token walks one cell per cycle, and the result
// is registered into the output register once it leaves the last cell.
// req_stall is high from acceptance until the result reaches the output register.
// A result blocked by a stalled output waits in a one-entry holding register.
// Reset clears the fill count and the handshake state; slot contents are kept,
// and only slots below the fill count are ever compared.
// ----------------------------------------------------------------------------
module keyed_value_cache_table #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  kvct_pkg::kvct_req_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output kvct_pkg::kvct_rsp_t rsp
);
	import kvct_pkg::*;

`include "keyed_value_cache_table_macros.svh"

	// The fill count must be able to hold the table size itself.
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

	logic            accept;
	logic            busy_q;
	logic [CW-1:0]   count_q;
	kvct_tok_t       tok_head;
	kvct_tok_t       tok [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] chain_vld;
	kvct_tok_t       exit_tok;
	kvct_rsp_t       res;
	kvct_rsp_t       fin_q;
	logic            fin_vld_q;
	kvct_rsp_t       rsp_q;
	logic            rsp_vld_q;
	logic            rsp_free;

	assign req_stall = busy_q;
	assign accept    = req_valid && !busy_q;
	assign rsp_free  = !rsp_vld_q || !rsp_stall;

	// The token enters the first cell in the cycle the request is accepted.
	always_comb begin
		tok_head            = '0;
		tok_head.vld        = accept;
		tok_head.cmd        = req.command;
		tok_head.clause_key = req.clause_key;
		tok_head.local_id   = req.local_id;
		tok_head.global_id  = req.global_id;
		tok_head.value_bits = req.value_bits;
	end

	assign tok[0] = tok_head;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			kvct_cell #(
				.INDEX(gi),
				.CW   (CW)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.tok_in (tok[gi]),
				.count  (count_q),
				.tok_out(tok[gi+1])
			);
			assign chain_vld[gi] = tok[gi+1].vld;
		end
	endgenerate

	assign exit_tok = tok[TABLE_ENTRIES];

	// Build the result once the token has passed every slot. A miss leaves
	// hit_value at zero, so the found value needs no extra masking.
	always_comb begin
		res             = '0;
		res.found       = exit_tok.hit;
		res.found_value = exit_tok.hit_value;
		case (exit_tok.cmd)
			CMD_INSERT: begin
				if (exit_tok.dup) begin
					res.status = ST_DUP;
				end else if (count_q == FULL_COUNT) begin
					res.status = ST_FULL;
				end else begin
					res.status = ST_DONE;
				end
			end
			default: begin
				res.status = ST_DONE;
			end
		endcase
	end

	// Fill count only changes when a token leaves the row, so every cell sees
	// the same count for the whole walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exit_tok.vld) begin
			case (exit_tok.cmd)
				CMD_INSERT: begin
					if (!exit_tok.dup && (count_q != FULL_COUNT)) begin
						count_q <= count_q + 1'b1;
					end
				end
				CMD_CLEAR: begin
					count_q <= '0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Busy flag, holding register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			fin_vld_q <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end
			if (exit_tok.vld) begin
				if (rsp_free) begin
					rsp_vld_q <= 1'b1;
					busy_q    <= 1'b0;
				end else begin
					fin_vld_q <= 1'b1;
				end
			end else if (fin_vld_q) begin
				if (rsp_free) begin
					rsp_vld_q <= 1'b1;
					fin_vld_q <= 1'b0;
					busy_q    <= 1'b0;
				end
			end else if (rsp_vld_q && !rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exit_tok.vld) begin
			if (rsp_free) begin
				rsp_q <= res;
			end else begin
				fin_q <= res;
			end
		end else if (fin_vld_q && rsp_free) begin
			rsp_q <= fin_q;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// The fill count never passes the table size.
	`KVCT_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_COUNT)
	// At most one token walks the row at a time.
	`KVCT_ASSERT_SAME(a_one_token, clk, arst_n, 1'b1, $countones(chain_vld) <= 1)
	// A token in the row always belongs to an accepted, unfinished transaction.
	`KVCT_ASSERT_SAME(a_token_busy, clk, arst_n, chain_vld != '0, busy_q && !fin_vld_q)
	// A held result means the output register is occupied.
	`KVCT_ASSERT_SAME(a_hold_full, clk, arst_n, fin_vld_q, rsp_vld_q && busy_q)
	// A clear leaves the table empty.
	`KVCT_ASSERT_NEXT(a_clear_empty, clk, arst_n, exit_tok.vld && (exit_tok.cmd == CMD_CLEAR), count_q == '0)

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed value cache table: a cycle-free mirror of
// the table predicts every response, and random traffic with idle phases
// exercises inserts, lookups, duplicates, overflow and clears.
// ----------------------------------------------------------------------------
module tb;
	import kvct_pkg::*;

	localparam int SLOTS = 64;

	// The package has no name for the spare command code; the block treats it
	// as a no-op that answers with an all-zero response.
	localparam logic [1:0] CMD_NOP = 2'd3;

	// Number of input transactions to send, directed part included.
	localparam int ITEM_TARGET = 1800;

	// Transactions per traffic phase before the bench moves to the next one.
	localparam int PHASE_LEN = 150;

	// Cycles without any accepted transaction on either channel before the run
	// is declared hung.
	localparam int QUIET_LIMIT = 4000;

	// Mirror of the table. It applies each accepted command to its own copy of
	// the slots and queues the response the block has to give.
	class cache_mirror;
		logic [31:0]  slot_clause [SLOTS];
		logic [31:0]  slot_local [SLOTS];
		logic [31:0]  slot_global [SLOTS];
		logic [63:0]  slot_value [SLOTS];
		int unsigned  fill;
		kvct_rsp_t    expected_rsps [$];
		int unsigned  mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function void apply_command(kvct_req_t cmd_in);
			kvct_rsp_t want;
			bit        hit;
			int        i;
			want = '0;
			hit = 1'b0;
			case (cmd_in.command)
				CMD_INSERT: begin
					// The duplicate search comes before the room check, so a
					// full table still reports a duplicate.
					for (i = 0; i < fill && !hit; i++) begin
						if (slot_clause[i] == cmd_in.clause_key &&
								slot_local[i] == cmd_in.local_id &&
								slot_global[i] == cmd_in.global_id) begin
							hit = 1'b1;
						end
					end
					if (hit) begin
						want.status = ST_DUP;
					end else if (fill >= SLOTS) begin
						want.status = ST_FULL;
					end else begin
						slot_clause[fill] = cmd_in.clause_key;
						slot_local[fill] = cmd_in.local_id;
						slot_global[fill] = cmd_in.global_id;
						slot_value[fill] = cmd_in.value_bits;
						fill++;
					end
				end
				CMD_LOOKUP: begin
					// Only the clause key and the global id take part; the
					// earliest filled slot wins.
					for (i = 0; i < fill && !hit; i++) begin
						if (slot_clause[i] == cmd_in.clause_key &&
								slot_global[i] == cmd_in.global_id) begin
							hit = 1'b1;
							want.found = 1'b1;
							want.found_value = slot_value[i];
						end
					end
				end
				CMD_CLEAR: begin
					fill = 0;
				end
				default: begin
				end
			endcase
			expected_rsps.push_back(want);
		endfunction

		function void compare_response(kvct_rsp_t got);
			kvct_rsp_t want;
			if (expected_rsps.size() == 0) begin
				$error("response with nothing outstanding: found %0d value %h status %0d",
					got.found, got.found_value, got.status);
				mismatches++;
				return;
			end
			want = expected_rsps.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				mismatches++;
			end
			if (got.found_value !== want.found_value) begin
				$error("found_value: expected %h, got %h", want.found_value,
					got.found_value);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	kvct_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	kvct_rsp_t rsp;

	cache_mirror mirror = new();

	int unsigned sent = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned quiet_cycles = 0;

	always #5 clk = ~clk;

	keyed_value_cache_table #(
		.TABLE_ENTRIES(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// The receiver stalls at random, at the rate of the current phase.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// Both channels are sampled at the edge, before any of this edge's
	// nonblocking updates land, so what is seen is what the block saw. A
	// request is noted before a response of the same edge is checked.
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			mirror.apply_command(req);
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			mirror.compare_response(rsp);
		end
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// A run in which nothing moves for too long has hung.
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic kvct_req_t make_req(logic [1:0] cmd, logic [31:0] ck,
			logic [31:0] li, logic [31:0] gi, logic [63:0] val);
		kvct_req_t r;
		r.command = cmd;
		r.clause_key = ck;
		r.local_id = li;
		r.global_id = gi;
		r.value_bits = val;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Key values lean on the corners of the signed range now and then.
	function automatic logic [31:0] pick_key();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Sends one transaction and returns at the edge that accepts it. Valid is
	// left high, so the next call either drops it for an idle cycle or puts
	// the next payload on the bus; either way it is assigned once per edge.
	task automatic send(kvct_req_t item);
		case ((sent / PHASE_LEN) % 4)
			0: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_idle_pct = 49;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct = 0;
				sink_stall_pct = 49;
			end
			default: begin
				src_idle_pct = 6;
				sink_stall_pct = 6;
			end
		endcase
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		sent++;
	endtask

	// Clears, fills every slot with distinct keys, then hits the full table
	// with duplicates, lookups of filled slots and inserts that cannot fit.
	task automatic fill_episode();
		logic [31:0] base_ck;
		logic [31:0] lis [SLOTS];
		logic [31:0] gis [SLOTS];
		int          i;
		int          k;
		base_ck = $urandom;
		send(make_req(CMD_CLEAR, $urandom, $urandom, $urandom, rand64()));
		for (i = 0; i < SLOTS; i++) begin
			lis[i] = $urandom;
			gis[i] = $urandom;
			send(make_req(CMD_INSERT, base_ck + i, lis[i], gis[i], rand64()));
		end
		repeat ($urandom_range(6, 14)) begin
			k = $urandom_range(SLOTS - 1);
			case ($urandom_range(2))
				0: send(make_req(CMD_INSERT, base_ck + k, lis[k], gis[k], rand64()));
				1: send(make_req(CMD_LOOKUP, base_ck + k, $urandom, gis[k], rand64()));
				default: send(make_req(CMD_INSERT, $urandom, $urandom, $urandom,
					rand64()));
			endcase
		end
	endtask

	// Works on a small pool of keys so that lookups hit, inserts collide and
	// several slots share a clause key and global id with different local ids.
	task automatic pool_episode();
		logic [31:0] cks [4];
		logic [31:0] lis [3];
		logic [31:0] gis [3];
		int          i;
		int          pick;
		for (i = 0; i < 4; i++) cks[i] = pick_key();
		for (i = 0; i < 3; i++) begin
			lis[i] = pick_key();
			gis[i] = pick_key();
		end
		if ($urandom_range(1) == 0) begin
			send(make_req(CMD_CLEAR, $urandom, $urandom, $urandom, rand64()));
		end
		repeat ($urandom_range(10, 40)) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				send(make_req(CMD_INSERT, cks[$urandom_range(3)], lis[$urandom_range(2)],
					gis[$urandom_range(2)], rand64()));
			end else if (pick < 90) begin
				send(make_req(CMD_LOOKUP, cks[$urandom_range(3)], $urandom,
					gis[$urandom_range(2)], rand64()));
			end else if (pick < 95) begin
				send(make_req(CMD_NOP, $urandom, $urandom, $urandom, rand64()));
			end else begin
				send(make_req(CMD_CLEAR, $urandom, $urandom, $urandom, rand64()));
			end
		end
	endtask

	// Unrelated random transactions of any command code.
	task automatic noise_episode();
		repeat ($urandom_range(5, 15)) begin
			send(make_req(2'($urandom_range(3)), $urandom, $urandom, $urandom,
				rand64()));
		end
	endtask

	initial begin
		int pick;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a miss on the empty table, corner keys and values,
		// a duplicate, two slots that share the lookup keys, a miss on each
		// lookup key, the spare command code, and stale slots after a clear.
		send(make_req(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 64'h0));
		send(make_req(CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
			64'hffff_ffff_ffff_ffff));
		send(make_req(CMD_INSERT, 32'h0, 32'h0, 32'h0, 64'h0));
		send(make_req(CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
			64'h8000_0000_0000_0001));
		send(make_req(CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
			64'h1234_5678_9abc_def0));
		send(make_req(CMD_INSERT, 32'h8000_0000, 32'h0, 32'hffff_ffff,
			64'h0000_0000_0000_0005));
		send(make_req(CMD_LOOKUP, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff,
			64'hffff_ffff_ffff_ffff));
		send(make_req(CMD_LOOKUP, 32'h0, 32'h1234_5678, 32'h0, 64'h0));
		send(make_req(CMD_LOOKUP, 32'h7fff_ffff, 32'h0, 32'h0, 64'h0));
		send(make_req(CMD_LOOKUP, 32'h0, 32'h0, 32'h0000_0001, 64'h0));
		send(make_req(CMD_LOOKUP, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 64'h0));
		send(make_req(CMD_LOOKUP, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 64'h0));
		send(make_req(CMD_NOP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			64'hffff_ffff_ffff_ffff));
		send(make_req(CMD_NOP, 32'h0, 32'h0, 32'h0, 64'h0));
		send(make_req(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			64'hffff_ffff_ffff_ffff));
		send(make_req(CMD_LOOKUP, 32'h8000_0000, 32'h0, 32'hffff_ffff, 64'h0));
		send(make_req(CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
			64'h0f0f_0f0f_f0f0_f0f0));
		send(make_req(CMD_LOOKUP, 32'h8000_0000, 32'h0, 32'hffff_ffff, 64'h0));
		send(make_req(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 64'h0));
		send(make_req(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 64'h0));

		// Random part. The first episode fills the table so that overflow is
		// seen early; after that the mix leans on pooled keys.
		fill_episode();
		while (sent < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				fill_episode();
			end else if (pick < 85) begin
				pool_episode();
			end else begin
				noise_episode();
			end
		end
		req_valid <= 1'b0;

		// Drain, then give the block time to show any stray response.
		while (mirror.expected_rsps.size() != 0) begin
			@(posedge clk);
		end
		repeat (2 * SLOTS + 16) @(posedge clk);

		if (mirror.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/kvct_pkg.sv
hdl/kvct_cell.sv
hdl/keyed_value_cache_table.sv
bench/tb.sv
